### hw/rtl/erv_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and arithmetic helpers for the Euler rotation block.
package erv_pkg;

    localparam int DATA_WIDTH  = 16;
    localparam int COEF_WIDTH  = 16;
    localparam int FRAC_BITS   = COEF_WIDTH - 2;
    localparam int ANGLE_W     = 16;
    localparam int CFG_INDEX_W = 2;

    // CORDIC: Q2.30 values, angle 2^32 per turn
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 4;
    localparam int Z_W          = 34;
    localparam int XY_W         = 34;
    localparam int TRIG_W       = 32;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

    // matrix build sequencer
    localparam int MUL_STEPS = 14;
    localparam int MSTEP_W   = 4;
    localparam int SUM_W     = TRIG_W + 2;
    localparam int COEF_SHIFT = 30 - FRAC_BITS;

    // vector datapath
    localparam int PROD_W = DATA_WIDTH + COEF_WIDTH;
    localparam int ACC_W  = PROD_W + 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROLL  = 2'd0,
        REG_PITCH = 2'd1,
        REG_YAW   = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        BLD_IDLE,
        BLD_CORDIC,
        BLD_MUL,
        BLD_SUM
    } bld_state_t;

    typedef logic signed [COEF_WIDTH-1:0] coef_t;
    typedef coef_t matrix_t [0:8];
    typedef logic signed [TRIG_W-1:0] trig_t;

    function automatic logic signed [Z_W-1:0] atan_lut(input logic [STEP_W-1:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            4'd0:    v = Z_W'(536870912);
            4'd1:    v = Z_W'(316933406);
            4'd2:    v = Z_W'(167458907);
            4'd3:    v = Z_W'(85004756);
            4'd4:    v = Z_W'(42667331);
            4'd5:    v = Z_W'(21354465);
            4'd6:    v = Z_W'(10679838);
            4'd7:    v = Z_W'(5340245);
            4'd8:    v = Z_W'(2670163);
            4'd9:    v = Z_W'(1335087);
            4'd10:   v = Z_W'(667544);
            4'd11:   v = Z_W'(333772);
            4'd12:   v = Z_W'(166886);
            4'd13:   v = Z_W'(83443);
            4'd14:   v = Z_W'(41722);
            default: v = Z_W'(20861);
        endcase
        return v;
    endfunction

    // Q2.30 sum to Q2.FRAC coefficient, round half up, saturate
    function automatic coef_t to_coef(input logic signed [SUM_W-1:0] v);
        localparam logic signed [SUM_W:0] RND =
            (SUM_W+1)'((64'sd1 <<< COEF_SHIFT) >>> 1);
        localparam logic signed [SUM_W:0] CMAX =
            (SUM_W+1)'((64'sd1 <<< (COEF_WIDTH-1)) - 64'sd1);
        localparam logic signed [SUM_W:0] CMIN = -CMAX - (SUM_W+1)'(1);
        logic signed [SUM_W:0] r;
        r = ((SUM_W+1)'(v) + RND) >>> COEF_SHIFT;
        if (r > CMAX)
            return CMAX[COEF_WIDTH-1:0];
        else if (r < CMIN)
            return CMIN[COEF_WIDTH-1:0];
        return r[COEF_WIDTH-1:0];
    endfunction

    // dot product to output sample, round half up, saturate
    function automatic logic signed [DATA_WIDTH-1:0] to_data(
        input logic signed [ACC_W-1:0] v);
        localparam logic signed [ACC_W:0] RND =
            (ACC_W+1)'(64'sd1 <<< (FRAC_BITS-1));
        localparam logic signed [ACC_W:0] DMAX =
            (ACC_W+1)'((64'sd1 <<< (DATA_WIDTH-1)) - 64'sd1);
        localparam logic signed [ACC_W:0] DMIN = -DMAX - (ACC_W+1)'(1);
        logic signed [ACC_W:0] r;
        r = ((ACC_W+1)'(v) + RND) >>> FRAC_BITS;
        if (r > DMAX)
            return DMAX[DATA_WIDTH-1:0];
        else if (r < DMIN)
            return DMIN[DATA_WIDTH-1:0];
        return r[DATA_WIDTH-1:0];
    endfunction

endpackage

### hw/rtl/erv_if.sv
`timescale 1ns / 1ps
// Handshake channel interfaces: vector in, vector out, configuration write.
interface erv_in_if import erv_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic signed [DATA_WIDTH-1:0] in_x;
    logic signed [DATA_WIDTH-1:0] in_y;
    logic signed [DATA_WIDTH-1:0] in_z;
    modport source (output valid, mode, in_x, in_y, in_z, input ready);
    modport sink   (input valid, mode, in_x, in_y, in_z, output ready);
endinterface

interface erv_out_if import erv_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] out_x;
    logic signed [DATA_WIDTH-1:0] out_y;
    logic signed [DATA_WIDTH-1:0] out_z;
    modport source (output valid, out_x, out_y, out_z, input ready);
    modport sink   (input valid, out_x, out_y, out_z, output ready);
endinterface

interface erv_cfg_if import erv_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [ANGLE_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/erv_cordic.sv
`timescale 1ns / 1ps
// Iterative rotation-mode CORDIC: one micro-rotation per cycle.
module erv_cordic
    import erv_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [ANGLE_W-1:0] angle,
    output logic                      done,
    output trig_t                     sin_val,
    output trig_t                     cos_val
);

    localparam logic signed [ANGLE_W:0] HALF_PI = (ANGLE_W+1)'(1 << (ANGLE_W-2));
    localparam logic signed [ANGLE_W:0] PI_VAL  = (ANGLE_W+1)'(1 << (ANGLE_W-1));

    logic                   run_reg, done_reg, neg_reg;
    logic [STEP_W-1:0]      step_reg;
    logic signed [XY_W-1:0] x_reg, y_reg;
    logic signed [Z_W-1:0]  z_reg;

    logic signed [ANGLE_W:0] a_ext, a_red;
    logic                    neg_next;
    logic signed [XY_W-1:0]  xs, ys, x_next, y_next;
    logic signed [Z_W-1:0]   z_next;

    // fold into [-pi/2, pi/2], flip both outputs
    always_comb
    begin
        a_ext    = (ANGLE_W+1)'(angle);
        a_red    = a_ext;
        neg_next = 1'b0;
        if (a_ext > HALF_PI)
        begin
            a_red    = a_ext - PI_VAL;
            neg_next = 1'b1;
        end
        else if (a_ext < -HALF_PI)
        begin
            a_red    = a_ext + PI_VAL;
            neg_next = 1'b1;
        end
    end

    always_comb
    begin
        xs = y_reg >>> step_reg;
        ys = x_reg >>> step_reg;
        if (!z_reg[Z_W-1])
        begin
            x_next = x_reg - xs;
            y_next = y_reg + ys;
            z_next = z_reg - atan_lut(step_reg);
        end
        else
        begin
            x_next = x_reg + xs;
            y_next = y_reg - ys;
            z_next = z_reg + atan_lut(step_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= CORDIC_GAIN;
            y_reg   <= '0;
            z_reg   <= Z_W'(a_red) <<< 16;
            neg_reg <= neg_next;
        end
        else if (run_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign done    = done_reg;
    assign cos_val = neg_reg ? -x_reg[TRIG_W-1:0] : x_reg[TRIG_W-1:0];
    assign sin_val = neg_reg ? -y_reg[TRIG_W-1:0] : y_reg[TRIG_W-1:0];

endmodule

### hw/rtl/erv_matrix_build.sv
`timescale 1ns / 1ps
// Angle registers and sequencer that rebuilds the rotation matrix.
module erv_matrix_build
    import erv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    erv_cfg_if.sink   cfg,
    output matrix_t   matrix,
    output logic      busy
);

    localparam coef_t ONE = COEF_WIDTH'(1 << FRAC_BITS);

    bld_state_t state_reg, state_next;
    logic [1:0]          sel_reg;
    logic [MSTEP_W-1:0]  mstep_reg;
    logic                kick_reg;
    logic signed [ANGLE_W-1:0] angle_reg [0:2];
    trig_t               sin_reg [0:2];
    trig_t               cos_reg [0:2];
    trig_t               prod_reg [0:MUL_STEPS-1];
    matrix_t             matrix_reg;

    logic        cfg_hit, cfg_take, cord_done;
    trig_t       cord_sin, cord_cos, opa, opb, mul_r;
    logic signed [2*TRIG_W-1:0] mul_full;
    logic signed [SUM_W-1:0]    t [0:8];

    always_comb
    begin
        case (reg_index_t'(cfg.index))
            REG_ROLL, REG_PITCH, REG_YAW: cfg_hit = 1'b1;
            default:                      cfg_hit = 1'b0;
        endcase
    end

    assign cfg_take = cfg.valid && cfg.ready;

    erv_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (kick_reg),
        .angle   (angle_reg[sel_reg]),
        .done    (cord_done),
        .sin_val (cord_sin),
        .cos_val (cord_cos)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BLD_IDLE:   if (cfg_take && cfg_hit) state_next = BLD_CORDIC;
            BLD_CORDIC: if (cord_done && sel_reg == 2'd2) state_next = BLD_MUL;
            BLD_MUL:    if (mstep_reg == MSTEP_W'(MUL_STEPS - 1)) state_next = BLD_SUM;
            BLD_SUM:    state_next = BLD_IDLE;
            default:    state_next = BLD_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cfg.ready = (state_reg == BLD_IDLE);
        busy      = (state_reg != BLD_IDLE);
    end

    // index 0 roll (g), 1 pitch (b), 2 yaw (a); products follow R = Rz*Ry*Rx
    always_comb
    begin
        case (mstep_reg)
            4'd0:    begin opa = cos_reg[2];  opb = cos_reg[1]; end
            4'd1:    begin opa = cos_reg[2];  opb = sin_reg[1]; end
            4'd2:    begin opa = prod_reg[1]; opb = sin_reg[0]; end
            4'd3:    begin opa = sin_reg[2];  opb = cos_reg[0]; end
            4'd4:    begin opa = prod_reg[1]; opb = cos_reg[0]; end
            4'd5:    begin opa = sin_reg[2];  opb = sin_reg[0]; end
            4'd6:    begin opa = sin_reg[2];  opb = cos_reg[1]; end
            4'd7:    begin opa = sin_reg[2];  opb = sin_reg[1]; end
            4'd8:    begin opa = prod_reg[7]; opb = sin_reg[0]; end
            4'd9:    begin opa = cos_reg[2];  opb = cos_reg[0]; end
            4'd10:   begin opa = prod_reg[7]; opb = cos_reg[0]; end
            4'd11:   begin opa = cos_reg[2];  opb = sin_reg[0]; end
            4'd12:   begin opa = cos_reg[1];  opb = sin_reg[0]; end
            default: begin opa = cos_reg[1];  opb = cos_reg[0]; end
        endcase
        mul_full = (2*TRIG_W)'(opa) * (2*TRIG_W)'(opb);
        mul_r    = TRIG_W'((mul_full + (2*TRIG_W)'(64'sd1 <<< 29)) >>> 30);
    end

    always_comb
    begin
        t[0] = SUM_W'(prod_reg[0]);
        t[1] = SUM_W'(prod_reg[2])  - SUM_W'(prod_reg[3]);
        t[2] = SUM_W'(prod_reg[4])  + SUM_W'(prod_reg[5]);
        t[3] = SUM_W'(prod_reg[6]);
        t[4] = SUM_W'(prod_reg[8])  + SUM_W'(prod_reg[9]);
        t[5] = SUM_W'(prod_reg[10]) - SUM_W'(prod_reg[11]);
        t[6] = -SUM_W'(sin_reg[1]);
        t[7] = SUM_W'(prod_reg[12]);
        t[8] = SUM_W'(prod_reg[13]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BLD_IDLE;
            sel_reg   <= '0;
            mstep_reg <= '0;
            kick_reg  <= 1'b0;
            for (int i = 0; i < 3; i++)
                angle_reg[i] <= '0;
            for (int k = 0; k < 9; k++)
                matrix_reg[k] <= (k % 4 == 0) ? ONE : '0;
        end
        else
        begin
            state_reg <= state_next;
            kick_reg  <= 1'b0;
            case (state_reg)
                BLD_IDLE:
                begin
                    if (cfg_take && cfg_hit)
                    begin
                        angle_reg[cfg.index] <= cfg.data;
                        sel_reg              <= '0;
                        kick_reg             <= 1'b1;
                    end
                end
                BLD_CORDIC:
                begin
                    if (cord_done)
                    begin
                        mstep_reg <= '0;
                        if (sel_reg != 2'd2)
                        begin
                            sel_reg  <= sel_reg + 2'd1;
                            kick_reg <= 1'b1;
                        end
                    end
                end
                BLD_MUL:
                    mstep_reg <= mstep_reg + MSTEP_W'(1);
                BLD_SUM:
                begin
                    for (int k = 0; k < 9; k++)
                        matrix_reg[k] <= to_coef(t[k]);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BLD_CORDIC && cord_done)
        begin
            sin_reg[sel_reg] <= cord_sin;
            cos_reg[sel_reg] <= cord_cos;
        end
        if (state_reg == BLD_MUL)
            prod_reg[mstep_reg] <= mul_r;
    end

    assign matrix = matrix_reg;

endmodule

### hw/rtl/erv_datapath.sv
`timescale 1ns / 1ps
// Three-stage vector pipeline: products, dot sums, round and saturate.
module erv_datapath
    import erv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      hold,
    input  matrix_t   matrix,
    erv_in_if.sink    vec_in,
    erv_out_if.source vec_out
);

    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3, take;
    logic signed [PROD_W-1:0]     p_reg [0:8];
    logic signed [PROD_W-1:0]     p_next [0:8];
    logic signed [ACC_W-1:0]      acc_reg [0:2];
    logic signed [DATA_WIDTH-1:0] o_reg [0:2];
    logic signed [DATA_WIDTH-1:0] vin [0:2];
    coef_t                        c;

    assign adv3 = !v3_reg || vec_out.ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign vec_in.ready = adv1 && !hold;
    assign take = vec_in.valid && vec_in.ready;

    assign vin[0] = vec_in.in_x;
    assign vin[1] = vec_in.in_y;
    assign vin[2] = vec_in.in_z;

    // mode 1 walks columns (transpose)
    always_comb
    begin
        c = '0;
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                c = vec_in.mode ? matrix[3*j+k] : matrix[3*k+j];
                p_next[3*k+j] = PROD_W'(vin[j]) * PROD_W'(c);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= take;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            p_reg <= p_next;
        if (adv2 && v1_reg)
        begin
            for (int k = 0; k < 3; k++)
                acc_reg[k] <= ACC_W'(p_reg[3*k]) + ACC_W'(p_reg[3*k+1])
                            + ACC_W'(p_reg[3*k+2]);
        end
        if (adv3 && v2_reg)
        begin
            for (int k = 0; k < 3; k++)
                o_reg[k] <= to_data(acc_reg[k]);
        end
    end

    assign vec_out.valid = v3_reg;
    assign vec_out.out_x = o_reg[0];
    assign vec_out.out_y = o_reg[1];
    assign vec_out.out_z = o_reg[2];

endmodule

### hw/rtl/euler_rotation_vector_transform.sv
`timescale 1ns / 1ps
// Beats pass product, sum and saturate registers; one beat per cycle unless held or stalled.
// Throughput is set by the three-stage multiply/sum/saturate pipeline, which stalls per stage.
// A config write of roll, pitch or yaw rebuilds the matrix: three CORDIC runs (start,
// 16 iterations, done), 14 shared-multiplier steps and a final sum state;
// input is held meanwhile. Reset: async active low; angles clear to 0, matrix to identity Q2.14.
module euler_rotation_vector_transform
    import erv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    erv_cfg_if.sink   cfg,
    erv_in_if.sink    vec_in,
    erv_out_if.source vec_out
);

    matrix_t matrix;
    logic    busy;
    logic    hold;

    // matrix build: angle registers, CORDIC, sequenced products
    erv_matrix_build u_build (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .matrix (matrix),
        .busy   (busy)
    );

    // no vector beat while the matrix is being rebuilt or a write is pending
    assign hold = busy || cfg.valid;

    erv_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .hold    (hold),
        .matrix  (matrix),
        .vec_in  (vec_in),
        .vec_out (vec_out)
    );

endmodule

### sim/erv_rotation_checker.sv
`timescale 1ns / 1ps
// Checker: watches config, vector and result channels, predicts rotated vectors and compares.
module erv_rotation_checker
    import erv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    erv_cfg_if.sink   cfg_mon,
    erv_in_if.sink    in_mon,
    erv_out_if.sink   out_mon,
    output int        fail_count,
    output int        pending,
    output int        vectors_seen,
    output int        cfg_seen
);

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] x;
        logic signed [DATA_WIDTH-1:0] y;
        logic signed [DATA_WIDTH-1:0] z;
    } vec_t;

    localparam longint TAN_TBL [16] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861};

    logic signed [ANGLE_W-1:0] roll_q, pitch_q, yaw_q;
    longint                    mtx [9];
    vec_t                      rotated_q [$];

    function automatic longint clamp(longint v, int w);
        longint hi, lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    task automatic trig(input logic signed [ANGLE_W-1:0] ang, output longint s,
                        output longint c);
        longint x, y, z, nx, a;
        bit     flip;
        x = 652032874;
        y = 0;
        a = ang;
        flip = 0;
        if (a > 16384) begin a -= 32768; flip = 1; end
        else if (a < -16384) begin a += 32768; flip = 1; end
        z = a * 65536;
        for (int i = 0; i < 16; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= TAN_TBL[i];
            end
            else
            begin
                nx = x + (y >>> i); y = y - (x >>> i); z += TAN_TBL[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic rebuild_matrix();
        longint sg, cg, sb, cb, sa, ca, t[9];
        trig(roll_q, sg, cg);
        trig(pitch_q, sb, cb);
        trig(yaw_q, sa, ca);
        t[0] = qmul(ca, cb);
        t[1] = qmul(qmul(ca, sb), sg) - qmul(sa, cg);
        t[2] = qmul(qmul(ca, sb), cg) + qmul(sa, sg);
        t[3] = qmul(sa, cb);
        t[4] = qmul(qmul(sa, sb), sg) + qmul(ca, cg);
        t[5] = qmul(qmul(sa, sb), cg) - qmul(ca, sg);
        t[6] = -sb;
        t[7] = qmul(cb, sg);
        t[8] = qmul(cb, cg);
        for (int k = 0; k < 9; k++)
            mtx[k] = clamp((t[k] + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS),
                           COEF_WIDTH);
    endtask

    function automatic logic signed [DATA_WIDTH-1:0] row_dot(longint a, longint b,
        longint c, longint m0, longint m1, longint m2);
        longint acc;
        acc = a * m0 + b * m1 + c * m2 + (64'sd1 <<< (FRAC_BITS - 1));
        return DATA_WIDTH'(clamp(acc >>> FRAC_BITS, DATA_WIDTH));
    endfunction

    function automatic vec_t rotate(logic tr, longint a, longint b, longint c);
        vec_t r;
        if (tr)
        begin
            r.x = row_dot(a, b, c, mtx[0], mtx[3], mtx[6]);
            r.y = row_dot(a, b, c, mtx[1], mtx[4], mtx[7]);
            r.z = row_dot(a, b, c, mtx[2], mtx[5], mtx[8]);
        end
        else
        begin
            r.x = row_dot(a, b, c, mtx[0], mtx[1], mtx[2]);
            r.y = row_dot(a, b, c, mtx[3], mtx[4], mtx[5]);
            r.z = row_dot(a, b, c, mtx[6], mtx[7], mtx[8]);
        end
        return r;
    endfunction

    assign pending = rotated_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        vec_t got, want;
        if (!rst_n)
        begin
            roll_q  = '0;
            pitch_q = '0;
            yaw_q   = '0;
            for (int k = 0; k < 9; k++)
                mtx[k] = (k % 4 == 0) ? (64'sd1 <<< FRAC_BITS) : 0;
            rotated_q.delete();
            fail_count   <= 0;
            vectors_seen <= 0;
            cfg_seen     <= 0;
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                got = '{out_mon.out_x, out_mon.out_y, out_mon.out_z};
                if (rotated_q.size() == 0)
                begin
                    $error("unexpected result beat x=%0d y=%0d z=%0d", got.x, got.y, got.z);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = rotated_q.pop_front();
                    if (got.x !== want.x)
                        $error("out_x expected %0d got %0d", want.x, got.x);
                    if (got.y !== want.y)
                        $error("out_y expected %0d got %0d", want.y, got.y);
                    if (got.z !== want.z)
                        $error("out_z expected %0d got %0d", want.z, got.z);
                    if (got !== want)
                        fail_count <= fail_count + 1;
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                rotated_q.push_back(rotate(in_mon.mode, in_mon.in_x, in_mon.in_y,
                                           in_mon.in_z));
                vectors_seen <= vectors_seen + 1;
            end
            // config is only written while idle; matrix updated in place
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                cfg_seen <= cfg_seen + 1;
                if (cfg_mon.index <= REG_YAW)
                begin
                    case (reg_index_t'(cfg_mon.index))
                        REG_ROLL:  roll_q  = cfg_mon.data;
                        REG_PITCH: pitch_q = cfg_mon.data;
                        default:   yaw_q   = cfg_mon.data;
                    endcase
                    rebuild_matrix();
                end
            end
        end
    end

endmodule

### sim/euler_rotation_vector_transform_test.sv
`timescale 1ns / 1ps
// Testbench top: drives angle writes and vector beats, gives the verdict.
module euler_rotation_vector_transform_test
    import erv_pkg::*;
;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count, pending, vectors_seen, cfg_seen;
    int   cycle_count = 0;
    int   send_idle_pct = 0;   // chance in 100 that the sender idles instead of sending
    int   recv_stall_pct = 0;  // chance in 100 that the receiver drops ready

    localparam int CYCLE_LIMIT = 400000;

    erv_cfg_if cfg_ch ();
    erv_in_if  in_ch ();
    erv_out_if out_ch ();

    euler_rotation_vector_transform dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch.sink),
        .vec_in  (in_ch.sink),
        .vec_out (out_ch.source)
    );

    erv_rotation_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_mon      (cfg_ch.sink),
        .in_mon       (in_ch.sink),
        .out_mon      (out_ch.sink),
        .fail_count   (fail_count),
        .pending      (pending),
        .vectors_seen (vectors_seen),
        .cfg_seen     (cfg_seen)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver: ready toggles at random at the stall rate of the current phase.
    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        in_ch.valid  = 1'b0;
        in_ch.mode   = 1'b0;
        in_ch.in_x   = '0;
        in_ch.in_y   = '0;
        in_ch.in_z   = '0;
        out_ch.ready = 1'b0;
    end

    // One angle register write; a beat moves when valid and ready meet.
    // Valid drops after the beat so calls can follow each other.
    task automatic write_angle(input logic [CFG_INDEX_W-1:0] idx,
                               input logic [ANGLE_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // One vector beat; the sender may idle first. Valid stays up across back-to-back beats.
    task automatic send_vector(input logic m, input logic [DATA_WIDTH-1:0] x,
                               input logic [DATA_WIDTH-1:0] y,
                               input logic [DATA_WIDTH-1:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode  <= m;
        in_ch.in_x  <= x;
        in_ch.in_y  <= y;
        in_ch.in_z  <= z;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Drain results, then leave time for any rebuild still running.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic logic [DATA_WIDTH-1:0] rand_sample();
        case ($urandom_range(5))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return DATA_WIDTH'($urandom_range(15)) - 16'd8;
            default: return DATA_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [ANGLE_W-1:0] rand_angle();
        case ($urandom_range(7))
            0:       return 16'h8000;          // minus pi
            1:       return 16'h7fff;
            2:       return 16'h4000;          // quadrant boundary
            3:       return 16'hc000;
            4:       return 16'h4001;
            default: return ANGLE_W'($urandom);
        endcase
    endfunction

    localparam logic [DATA_WIDTH-1:0] EDGE_VALS [6] =
        '{16'h7fff, 16'h8000, 16'h0000, 16'h0001, 16'hffff, 16'h5555};

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity matrix at reset: extremes pass straight through, both modes.
        for (int k = 0; k < 6; k++)
            send_vector(k[0], EDGE_VALS[k], EDGE_VALS[5 - k], EDGE_VALS[(k + 2) % 6]);
        settle();

        // Roll -pi, pitch near pi, yaw pi/2, unmapped index; then saturating sums.
        write_angle(REG_ROLL, 16'h8000);
        write_angle(REG_PITCH, 16'h7fff);
        write_angle(REG_YAW, 16'h4000);
        write_angle(2'd3, 16'h1234);   // unmapped index, no effect
        settle();
        for (int k = 0; k < 8; k++)
            send_vector(k[0], k[1] ? 16'h8000 : 16'h7fff, k[2] ? 16'h8000 : 16'h7fff,
                        16'h7fff);
        settle();
        write_angle(REG_ROLL, 16'h2000);
        write_angle(REG_PITCH, 16'hc000);
        write_angle(REG_YAW, 16'h6000);
        settle();
        for (int k = 0; k < 6; k++)
            send_vector(k[0], 16'h7fff, 16'h8000, 16'h7fff);
        settle();

        // Random part: new angles each round, idle and stall mix cycles through the phases.
        for (int round = 0; round < 19; round++)
        begin
            case (round % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            write_angle(REG_ROLL, rand_angle());
            write_angle(REG_PITCH, rand_angle());
            write_angle(REG_YAW, rand_angle());
            if ($urandom_range(3) == 0)
                write_angle(2'd3, ANGLE_W'($urandom));
            settle();
            for (int n = 0; n < 48; n++)
                send_vector(1'($urandom), rand_sample(), rand_sample(), rand_sample());
            settle();
        end

        $display("covered %0d vector beats and %0d angle writes, both modes,",
                 vectors_seen, cfg_seen);
        $display("angle extremes incl. minus pi, saturating inputs, idle/stall phases");
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/erv_pkg.sv
hw/rtl/erv_if.sv
hw/rtl/erv_cordic.sv
hw/rtl/erv_matrix_build.sv
hw/rtl/erv_datapath.sv
hw/rtl/euler_rotation_vector_transform.sv
sim/erv_rotation_checker.sv
sim/euler_rotation_vector_transform_test.sv
